>>> sv/samtok_pkg.sv
// Shared types, field codes and character constants for the SAM record tokenizer.
`default_nettype none

package samtok_pkg;

  localparam int MAX_LINE = 4096;
  localparam int OFS_W    = $clog2(MAX_LINE) + 1;
  localparam int NUM_W    = 32;
  localparam int N_TEXT   = 6;

  typedef logic [OFS_W-1:0] ofs_t;
  typedef logic [3:0]       fld_t;

  // Field numbers along a line, QNAME first
  localparam fld_t FLD_QNAME = 4'd1;
  localparam fld_t FLD_FLAG  = 4'd2;
  localparam fld_t FLD_RNAME = 4'd3;
  localparam fld_t FLD_POS   = 4'd4;
  localparam fld_t FLD_MAPQ  = 4'd5;
  localparam fld_t FLD_CIGAR = 4'd6;
  localparam fld_t FLD_RNEXT = 4'd7;
  localparam fld_t FLD_PNEXT = 4'd8;
  localparam fld_t FLD_TLEN  = 4'd9;
  localparam fld_t FLD_SEQ   = 4'd10;
  localparam fld_t FLD_QUAL  = 4'd11;
  localparam fld_t FLD_OPT   = 4'd12;

  // Slots of the offset table
  localparam int OS_RNAME = 0;
  localparam int OS_CIGAR = 1;
  localparam int OS_RNEXT = 2;
  localparam int OS_SEQ   = 3;
  localparam int OS_QUAL  = 4;
  localparam int OS_OPT   = 5;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_AT    = 8'h40;

  typedef enum logic [2:0] {
    PH_SKIP   = 3'b001,
    PH_DIGITS = 3'b010,
    PH_DONE   = 3'b100
  } phase_t;

  typedef struct packed {
    logic [NUM_W-1:0] acc;
    logic             neg;
    phase_t           phase;
  } num_state_t;

  typedef struct packed {
    logic             is_header;
    logic [15:0]      flag_value;
    logic [31:0]      position;
    logic [7:0]       map_quality;
    logic [31:0]      mate_position;
    logic [31:0]      template_length;
    ofs_t             ref_name_offset;
    ofs_t             cigar_offset;
    ofs_t             mate_ref_offset;
    ofs_t             sequence_offset;
    ofs_t             quality_offset;
    ofs_t             tags_offset;
  } result_t;

  localparam num_state_t NUM_CLEAR = '{acc: '0, neg: 1'b0, phase: PH_SKIP};

endpackage

`default_nettype wire

>>> sv/samtok_atoi.sv
// One byte step of the atoi-style number reader: blanks, sign, digits with wrap.
`default_nettype none

module samtok_atoi
  import samtok_pkg::*;
(
  input  var num_state_t       cur,
  input  var logic [7:0]       data_byte,
  output num_state_t           nxt,
  output logic                 cap_en,
  output logic [NUM_W-1:0]     cap_val
);

  logic             digit;
  logic             blank;
  logic [3:0]       dval;
  logic [NUM_W-1:0] acc_step;

  assign digit    = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
  assign blank    = (data_byte == CH_SPACE) || (data_byte == CH_LF) || (data_byte == CH_VT)
                 || (data_byte == CH_FF) || (data_byte == CH_CR);
  assign dval     = 4'(data_byte - CH_ZERO);
  // acc * 10 + digit as two shifts and two adds, wrapping at 32 bits
  assign acc_step = (cur.acc << 3) + (cur.acc << 1) + {{(NUM_W-4){1'b0}}, dval};
  assign cap_val  = cur.neg ? (~acc_step + 1'b1) : acc_step;

  always_comb begin
    nxt    = cur;
    cap_en = 1'b0;
    unique case (cur.phase)
      PH_SKIP: begin
        if (blank) begin
          nxt.phase = PH_SKIP;
        end else if (data_byte == CH_PLUS) begin
          nxt.phase = PH_DIGITS;
        end else if (data_byte == CH_MINUS) begin
          nxt.neg   = 1'b1;
          nxt.phase = PH_DIGITS;
        end else if (!digit) begin
          nxt.phase = PH_DONE;
        end else begin
          nxt.phase = PH_DIGITS;
          nxt.acc   = acc_step;
          cap_en    = 1'b1;
        end
      end
      PH_DIGITS: begin
        if (digit) begin
          nxt.acc = acc_step;
          cap_en  = 1'b1;
        end else begin
          nxt.phase = PH_DONE;
        end
      end
      PH_DONE: nxt.phase = PH_DONE;
      default: nxt.phase = PH_DONE;
    endcase
  end

endmodule

`default_nettype wire

>>> sv/samtok_core.sv
// Per-line tokenizer state: field split, offsets, captured numbers and line result.
`default_nettype none

module samtok_core
  import samtok_pkg::*;
(
  input  var logic       clk,
  input  var logic       rst,
  input  var logic       step,
  input  var logic [7:0] data_byte,
  input  var logic       end_of_line,
  output result_t        result
);

  fld_t             field_index, field_index_next;
  ofs_t             byte_count, byte_count_next;
  ofs_t             trimmed_length, trimmed_length_next;
  num_state_t       num, num_next;
  logic             header_line, header_line_next;
  logic [15:0]      cap_flag, cap_flag_next;
  logic [31:0]      cap_pos, cap_pos_next;
  logic [7:0]       cap_mapq, cap_mapq_next;
  logic [31:0]      cap_pnext, cap_pnext_next;
  logic [31:0]      cap_tlen, cap_tlen_next;
  ofs_t             ofs      [N_TEXT];
  ofs_t             ofs_next [N_TEXT];

  num_state_t       atoi_nxt;
  logic             atoi_cap;
  logic [NUM_W-1:0] atoi_val;
  logic             in_range;
  logic             tab_split;
  ofs_t             pos1;
  fld_t             field_up;

  samtok_atoi u_atoi (
    .cur       (num),
    .data_byte (data_byte),
    .nxt       (atoi_nxt),
    .cap_en    (atoi_cap),
    .cap_val   (atoi_val)
  );

  assign in_range  = byte_count < OFS_W'(MAX_LINE);
  assign pos1      = byte_count + 1'b1;
  assign field_up  = field_index + 1'b1;
  assign tab_split = (data_byte == CH_TAB) && (field_index < FLD_OPT);

  always_comb begin
    field_index_next    = field_index;
    byte_count_next     = byte_count;
    trimmed_length_next = trimmed_length;
    num_next            = num;
    header_line_next    = header_line;
    cap_flag_next       = cap_flag;
    cap_pos_next        = cap_pos;
    cap_mapq_next       = cap_mapq;
    cap_pnext_next      = cap_pnext;
    cap_tlen_next       = cap_tlen;
    for (int i = 0; i < N_TEXT; i++) ofs_next[i] = ofs[i];

    if (in_range) begin
      if ((byte_count == '0) && (data_byte == CH_AT)) header_line_next = 1'b1;
      if (((data_byte != CH_CR) && (data_byte != CH_LF)) || (byte_count == '0)) begin
        trimmed_length_next = pos1;
      end
      byte_count_next = pos1;
      if (tab_split) begin
        field_index_next = field_up;
        num_next         = NUM_CLEAR;
        case (field_up)
          FLD_RNAME: ofs_next[OS_RNAME] = pos1;
          FLD_CIGAR: ofs_next[OS_CIGAR] = pos1;
          FLD_RNEXT: ofs_next[OS_RNEXT] = pos1;
          FLD_SEQ:   ofs_next[OS_SEQ]   = pos1;
          FLD_QUAL:  ofs_next[OS_QUAL]  = pos1;
          FLD_OPT:   ofs_next[OS_OPT]   = pos1;
          default: ;
        endcase
      end else begin
        case (field_index) inside
          FLD_FLAG, FLD_POS, FLD_MAPQ, FLD_PNEXT, FLD_TLEN: num_next = atoi_nxt;
          default: ;
        endcase
        if (atoi_cap) begin
          case (field_index)
            FLD_FLAG:  cap_flag_next  = atoi_val[15:0];
            FLD_POS:   cap_pos_next   = atoi_val;
            FLD_MAPQ:  cap_mapq_next  = atoi_val[7:0];
            FLD_PNEXT: cap_pnext_next = atoi_val;
            FLD_TLEN:  cap_tlen_next  = atoi_val;
            default: ;
          endcase
        end
      end
    end
  end

  // Line result from the state after this byte; a missing field reads as zero / length
  always_comb begin
    result = '0;
    if (header_line_next) begin
      result.is_header = 1'b1;
    end else begin
      result.flag_value      = cap_flag_next;
      result.position        = cap_pos_next;
      result.map_quality     = cap_mapq_next;
      result.mate_position   = cap_pnext_next;
      result.template_length = cap_tlen_next;
      result.ref_name_offset = (ofs_next[OS_RNAME] != '0) ? ofs_next[OS_RNAME]
                                                            : trimmed_length_next;
      result.cigar_offset    = (ofs_next[OS_CIGAR] != '0) ? ofs_next[OS_CIGAR]
                                                            : trimmed_length_next;
      result.mate_ref_offset = (ofs_next[OS_RNEXT] != '0) ? ofs_next[OS_RNEXT]
                                                            : trimmed_length_next;
      result.sequence_offset = (ofs_next[OS_SEQ] != '0) ? ofs_next[OS_SEQ]
                                                          : trimmed_length_next;
      result.quality_offset  = (ofs_next[OS_QUAL] != '0) ? ofs_next[OS_QUAL]
                                                           : trimmed_length_next;
      result.tags_offset     = (ofs_next[OS_OPT] != '0) ? ofs_next[OS_OPT]
                                                          : trimmed_length_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && end_of_line)) begin
      field_index    <= FLD_QNAME;
      byte_count     <= '0;
      trimmed_length <= '0;
      num            <= NUM_CLEAR;
      header_line    <= 1'b0;
      cap_flag       <= '0;
      cap_pos        <= '0;
      cap_mapq       <= '0;
      cap_pnext      <= '0;
      cap_tlen       <= '0;
      for (int i = 0; i < N_TEXT; i++) ofs[i] <= '0;
    end else if (step) begin
      field_index    <= field_index_next;
      byte_count     <= byte_count_next;
      trimmed_length <= trimmed_length_next;
      num            <= num_next;
      header_line    <= header_line_next;
      cap_flag       <= cap_flag_next;
      cap_pos        <= cap_pos_next;
      cap_mapq       <= cap_mapq_next;
      cap_pnext      <= cap_pnext_next;
      cap_tlen       <= cap_tlen_next;
      for (int i = 0; i < N_TEXT; i++) ofs[i] <= ofs_next[i];
    end
  end

  a_field_range: assert property (@(posedge clk) disable iff (rst)
    (field_index >= FLD_QNAME) && (field_index <= FLD_OPT))
    else $error("field index out of range");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    byte_count <= OFS_W'(MAX_LINE))
    else $error("byte count ran past line limit");

  a_trim_le_count: assert property (@(posedge clk) disable iff (rst)
    trimmed_length <= byte_count)
    else $error("trimmed length beyond byte count");

endmodule

`default_nettype wire

>>> sv/sam_record_field_tokenizer_top.sv
// Top level of the SAM record tokenizer: input register, tokenizer core, result register.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------------------
//   in      | to block  | in_valid/in_stall  | data_byte, end_of_line (one line byte)
//   out     | from block| out_valid/out_stall| is_header, numbers, six byte offsets
//
// Takes one byte per cycle unless a line end waits on a stalled result; a line result is
// valid once its last byte has passed the input register, which steps the core, and
// the result register has loaded it.
// The per-byte work is one multiply-by-ten add and a few compares in the core.
// Reset is synchronous; no clearing pass follows.
// A stalled output only holds back a last-of-line byte in the input register;
// other bytes keep flowing while a finished result waits.
`default_nettype none

module sam_record_field_tokenizer_top
  import samtok_pkg::*;
(
  input  var logic        clk,
  input  var logic        rst,

  input  var logic        in_valid,
  output logic            in_stall,
  input  var logic [7:0]  data_byte,
  input  var logic        end_of_line,

  output logic            out_valid,
  input  var logic        out_stall,
  output logic            is_header,
  output logic [15:0]     flag_value,
  output logic [31:0]     position,
  output logic [7:0]      map_quality,
  output logic [31:0]     mate_position,
  output logic [31:0]     template_length,
  output logic [12:0]     ref_name_offset,
  output logic [12:0]     cigar_offset,
  output logic [12:0]     mate_ref_offset,
  output logic [12:0]     sequence_offset,
  output logic [12:0]     quality_offset,
  output logic [12:0]     tags_offset
);

  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       hold_eol;
  logic       advance;
  logic       accept;
  result_t    core_result;
  result_t    out_reg;

  // Advance the held item unless it closes a line and the result slot stays busy
  assign advance  = hold_valid && (!hold_eol || !out_valid || !out_stall);
  assign in_stall = hold_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  // Payload of the input register; no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      hold_byte <= data_byte;
      hold_eol  <= end_of_line;
    end
  end

  samtok_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .data_byte   (hold_byte),
    .end_of_line (hold_eol),
    .result      (core_result)
  );

  // Result register: load on a line end, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && hold_eol) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hold_eol) begin
      out_reg <= core_result;
    end
  end

  assign is_header       = out_reg.is_header;
  assign flag_value      = out_reg.flag_value;
  assign position        = out_reg.position;
  assign map_quality     = out_reg.map_quality;
  assign mate_position   = out_reg.mate_position;
  assign template_length = out_reg.template_length;
  assign ref_name_offset = out_reg.ref_name_offset;
  assign cigar_offset    = out_reg.cigar_offset;
  assign mate_ref_offset = out_reg.mate_ref_offset;
  assign sequence_offset = out_reg.sequence_offset;
  assign quality_offset  = out_reg.quality_offset;
  assign tags_offset     = out_reg.tags_offset;

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (hold_eol && out_valid && out_stall))
    else $error("input stalled without a blocked line result");

  a_header_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_header) |-> ((flag_value == '0) && (position == '0)
      && (template_length == '0) && (tags_offset == '0)))
    else $error("header result carries record fields");

  a_offsets_set: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !is_header) |-> ((tags_offset != '0) && (ref_name_offset != '0)))
    else $error("record result with zero offset");

  a_line_end_loads: assert property (@(posedge clk) disable iff (rst)
    (advance && hold_eol) |=> out_valid)
    else $error("line end did not produce a result");

endmodule

`default_nettype wire
